### rtl/assert_macros.svh
// Assertion macros for the RTL of the LIS block, used by lis_ctrl.
// Both macros expect clk in scope at the point of use; LIS_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define LIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LIS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lis_pkg.sv
// Shared types and constants for the longest increasing subsequence block.
// No dependencies.
`default_nettype none

package lis_pkg;

  localparam int ELEM_W    = 32;
  localparam int LEN_OUT_W = 11;

  typedef logic signed [ELEM_W-1:0] elem_t;

  // One result item, controller to output register
  typedef struct packed {
    logic [LEN_OUT_W-1:0] lis_length;
    logic                 sequence_end;
    logic                 overflow;
  } lis_res_t;

endpackage

`default_nettype wire

### rtl/longest_increasing_subsequence.sv
// Longest strictly increasing subsequence, patience method.
// Input channel: in_valid/in_ready, one signed 32-bit element per transfer,
//   in_last_element marks the end of a sequence.
// Result channel: out_valid/out_ready, one result per input transfer:
//   out_lis_length (length after this element), out_sequence_end, and
//   out_overflow when the element would extend a full table and is dropped.
// Timing: one item at a time. An item runs a binary search of P probes,
//   P being about log2(length + 1), then its result load; the next transfer
//   follows the load. The search is bounded by the single read port of the
//   tail memory, one probe per cycle, with the compare and next address
//   resolved in the same cycle.
// The result sits in an output register; a new element is accepted while it
//   waits. If the receiver stalls, the next item finishes its search and
//   holds before its table write until the register frees.
// Reset clears the current length and all control state; tail memory
//   contents are not cleared and only written entries are ever read.
// Depends on lis_pkg, lis_ctrl and lis_tail_mem.
`default_nettype none

module longest_increasing_subsequence #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [31:0]               in_element,
  input  wire logic                             in_last_element,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [lis_pkg::LEN_OUT_W-1:0]         out_lis_length,
  output logic                                  out_sequence_end,
  output logic                                  out_overflow
);
  import lis_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  logic          res_valid, res_ready;
  lis_res_t      res;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  elem_t         wr_data, rd_data;

  logic          out_valid_r;
  lis_res_t      out_res_r;

  lis_ctrl #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .LW      (LW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_element      (in_element),
    .in_last_element (in_last_element),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  lis_tail_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lis_length   = out_res_r.lis_length;
  assign out_sequence_end = out_res_r.sequence_end;
  assign out_overflow     = out_res_r.overflow;

endmodule

`default_nettype wire

### rtl/lis_tail_mem.sv
// Tail table storage: one write port, one read port, registered read data.
// Depends on lis_pkg for the element type.
`default_nettype none

module lis_tail_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire lis_pkg::elem_t  wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output lis_pkg::elem_t       rd_data
);
  import lis_pkg::*;

  elem_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/lis_ctrl.sv
// Search and update sequencer: lower-bound binary search over the tail
// memory, one probe per cycle, then the slot write. Depends on lis_pkg.
`default_nettype none
`include "assert_macros.svh"

module lis_ctrl #(
  parameter int MAX_LEN = 1024,
  parameter int AW      = 10,
  parameter int LW      = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lis_pkg::elem_t   in_element,
  input  wire logic             in_last_element,
  // result toward the output register
  output logic                  res_valid,
  input  wire logic             res_ready,
  output lis_pkg::lis_res_t     res,
  // tail memory
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output lis_pkg::elem_t        wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  wire lis_pkg::elem_t   rd_data
);
  import lis_pkg::*;

  localparam logic [LW-1:0] MAX_LEN_L = LW'(MAX_LEN);
  localparam logic [LW-1:0] ONE_L     = LW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WR
  } state_t;

  state_t        state_r;
  elem_t         x_r;
  logic          last_r;
  logic [LW-1:0] lo_r, hi_r, mid_r, len_r;

  logic [LW-1:0] lo_c, hi_c, span_c, mid_c, len_new;
  logic [LW+LEN_OUT_W-1:0] len_ext;
  logic          in_fire, go_rd, lt_c, hit_c, full_c, ovf_c, res_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign res_fire = res_valid && res_ready;

  // Probe result: tail at mid is below the element
  assign lt_c = rd_data < x_r;

  // Next search window and its midpoint
  always_comb begin
    lo_c = lo_r;
    hi_c = hi_r;
    case (state_r)
      S_IDLE: begin
        lo_c = '0;
        hi_c = len_r;
      end
      S_CMP: begin
        if (lt_c) begin
          lo_c = mid_r + ONE_L;
        end else begin
          hi_c = mid_r;
        end
      end
      default: begin
        lo_c = lo_r;
        hi_c = hi_r;
      end
    endcase
    span_c = hi_c - lo_c;
    mid_c  = lo_c + (span_c >> 1);
  end

  assign go_rd   = lo_c < hi_c;
  assign rd_en   = go_rd && (in_fire || (state_r == S_CMP));
  assign rd_addr = mid_c[AW-1:0];

  // Slot update: overwrite inside the table, append at the end, or drop
  assign hit_c   = lo_r < len_r;
  assign full_c  = (len_r == MAX_LEN_L);
  assign ovf_c   = !hit_c && full_c;
  assign len_new = (!hit_c && !full_c) ? (len_r + ONE_L) : len_r;

  assign wr_en   = res_fire && !ovf_c;
  assign wr_addr = lo_r[AW-1:0];
  assign wr_data = x_r;

  // Result item
  assign len_ext          = {{LEN_OUT_W{1'b0}}, len_new};
  assign res_valid        = (state_r == S_WR);
  assign res.lis_length   = len_ext[LEN_OUT_W-1:0];
  assign res.sequence_end = last_r;
  assign res.overflow     = ovf_c;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            x_r    <= in_element;
            last_r <= in_last_element;
            lo_r   <= lo_c;
            hi_r   <= hi_c;
            mid_r  <= mid_c;
            state_r <= go_rd ? S_CMP : S_WR;
          end
        end
        S_CMP: begin
          lo_r  <= lo_c;
          hi_r  <= hi_c;
          mid_r <= mid_c;
          if (!go_rd) begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          if (res_ready) begin
            len_r   <= last_r ? '0 : len_new;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `LIS_ASSERT(a_len_bound, len_r <= MAX_LEN_L, "length beyond table capacity")
  `LIS_ASSERT(a_probe_window, (state_r == S_CMP) |-> (lo_r < hi_r), "probe with empty window")
  `LIS_ASSERT(a_ovf_full, (res_fire && res.overflow) |-> (len_r == MAX_LEN_L), "overflow below capacity")
  `LIS_ASSERT_RST(a_rst_clear, !rst_n |=> ((len_r == '0) && (state_r == S_IDLE)), "reset did not clear")

endmodule

`default_nettype wire
